[rtl/kts_pkg.sv]
// ----------------------------------------------------------------------------
// kts_pkg
// shared types and constants for the keyframe track sampler
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int CNT_W    = KEY_AW + 1;
  localparam int KEY_W    = 4 * 32 + 2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_SMOOTH = 2'd1;
  localparam logic [1:0] MODE_STEP   = 2'd2;

  localparam logic CFG_KEY_COUNT = 1'b0;
  localparam logic CFG_EMPTY_ONE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [5:0]         key_slot;
    logic signed [31:0] key_stamp;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic [1:0]         key_mode;
    logic signed [31:0] sample_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [5:0]         segment_used;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
    logic [31:0] stamp;
  } key_t;

endpackage

[rtl/keyframe_track_sampler.sv]
// ----------------------------------------------------------------------------
// keyframe_track_sampler
// keyframe track store with segment search, factor divide, shaping and lerp
// ----------------------------------------------------------------------------
// load transfer: written straight into the key ram, no result
// sample transfer: a scan checking one stamp a cycle off the key ram read port,
//   then a segment read, the restoring factor divider, a square, a shape, the
//   shared blend multiplier and an emit; the next transfer is taken in the cycle
//   after the emit
// one item at a time; a finished result waits in the output register
// reset (rst_n, synchronous) clears control state and config registers; the key ram
//   is not cleared and holds garbage until written
// ----------------------------------------------------------------------------
module keyframe_track_sampler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kts_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output kts_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [6:0]          cfg_wdata
);
  import kts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SEG_RD, ST_LAST_RD, ST_DIV,
    ST_SQ, ST_SHAPE, ST_BLEND, ST_EMIT
  } state_t;

  state_t state_r;

  // config registers
  logic [6:0] key_count_r;
  logic       empty_one_r;

  // per sample working registers
  logic signed [31:0] t_r;
  logic [CNT_W-1:0]   n_r;
  logic [CNT_W-1:0]   ra_r;     // address read this cycle
  logic [CNT_W-1:0]   ca_r;     // address whose data is on the ram output
  logic               cv_r;     // ram output carries a scanned stamp
  logic               first_r;
  logic [KEY_AW-1:0]  idx_r;
  key_t               kb_r;     // successor key
  key_t               ka_r;     // start key
  logic [32:0]        dt_r;
  logic [33:0]        rem_r;
  logic [15:0]        q_r;
  logic [3:0]         dcnt_r;
  logic [16:0]        f_r;
  logic [33:0]        sq_r;
  logic [16:0]        w_r;
  logic [1:0]         comp_r;
  out_item_t          res_r;
  out_item_t          out_r;
  logic               out_v_r;

  // ram
  logic              ram_we;
  logic [KEY_AW-1:0] ram_raddr;
  key_t              ram_wdata, ram_rdata;

  logic in_acc, out_acc, emit;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_v_r && !out_stall;
  // result handed over once the output register is free
  assign emit    = (state_r == ST_EMIT) && (!out_v_r || !out_stall);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  assign ram_we    = in_acc && (in_item.opcode == OP_LOAD);
  assign ram_wdata = '{mode: in_item.key_mode, z: in_item.key_z, y: in_item.key_y,
                       x: in_item.key_x, stamp: in_item.key_stamp};

  kts_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_item.key_slot[KEY_AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scan decisions
  logic              hit, miss_all;
  logic [CNT_W-1:0]  ca_m1, n_m1;
  assign hit      = (state_r == ST_SCAN) && cv_r && (t_r < $signed(ram_rdata.stamp));
  assign miss_all = (state_r == ST_SCAN) && !cv_r && !first_r;
  assign ca_m1    = ca_r - CNT_W'(1);
  assign n_m1     = n_r - CNT_W'(1);

  always_comb begin
    if (hit) begin
      ram_raddr = ca_m1[KEY_AW-1:0];
    end else if (miss_all) begin
      ram_raddr = n_m1[KEY_AW-1:0];
    end else begin
      ram_raddr = ra_r[KEY_AW-1:0];
    end
  end

  // clamp of the key count
  logic [CNT_W-1:0] n_clamp;
  assign n_clamp = (key_count_r > 7'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : key_count_r[CNT_W-1:0];

  // factor set-up from the start key on the ram output
  logic signed [32:0] dt_s, num_s;
  assign dt_s  = $signed({kb_r.stamp[31], kb_r.stamp}) - $signed({ram_rdata.stamp[31],
                 ram_rdata.stamp});
  assign num_s = $signed({t_r[31], t_r}) - $signed({ram_rdata.stamp[31], ram_rdata.stamp});

  // restoring divide step
  logic [33:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem_r[32:0], 1'b0};
  assign ge     = (rem_sh >= {1'b0, dt_r});

  // smoothstep
  logic [17:0] tail;
  logic [51:0] ss_p;
  assign tail = 18'(3 * 65536) - {f_r, 1'b0};
  assign ss_p = sq_r * tail;

  // blend, one component a cycle through one multiplier
  logic signed [31:0] a_c, b_c;
  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [31:0] blend_c;
  always_comb begin
    case (comp_r)
      2'd0:    begin a_c = $signed(ka_r.x); b_c = $signed(kb_r.x); end
      2'd1:    begin a_c = $signed(ka_r.y); b_c = $signed(kb_r.y); end
      default: begin a_c = $signed(ka_r.z); b_c = $signed(kb_r.z); end
    endcase
  end
  assign diff    = $signed({b_c[31], b_c}) - $signed({a_c[31], a_c});
  assign prod    = diff * $signed({1'b0, w_r});
  assign blend_c = a_c + prod[47:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_count_r <= '0;
      empty_one_r <= 1'b0;
      out_v_r     <= 1'b0;
      ra_r        <= '0;
      ca_r        <= '0;
      cv_r        <= 1'b0;
      first_r     <= 1'b0;
      dcnt_r      <= '0;
      comp_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_KEY_COUNT: key_count_r <= cfg_wdata;
          CFG_EMPTY_ONE: empty_one_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_acc) begin
        out_v_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_item.opcode == OP_SAMPLE) begin
            t_r     <= in_item.sample_time;
            n_r     <= n_clamp;
            ra_r    <= CNT_W'(1);
            cv_r    <= 1'b0;
            first_r <= 1'b1;
            if (n_clamp == '0) begin
              // empty track
              res_r.out_x        <= empty_one_r ? 32'sd65536 : 32'sd0;
              res_r.out_y        <= empty_one_r ? 32'sd65536 : 32'sd0;
              res_r.out_z        <= empty_one_r ? 32'sd65536 : 32'sd0;
              res_r.segment_used <= '0;
              state_r            <= ST_EMIT;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // one stamp read issued and one checked every cycle
          first_r <= 1'b0;
          ra_r    <= ra_r + CNT_W'(1);
          ca_r    <= ra_r;
          cv_r    <= (ra_r < n_r);
          if (hit) begin
            idx_r   <= ca_m1[KEY_AW-1:0];
            kb_r    <= ram_rdata;
            state_r <= ST_SEG_RD;
          end else if (miss_all) begin
            idx_r   <= n_m1[KEY_AW-1:0];
            state_r <= ST_LAST_RD;
          end
        end
        ST_LAST_RD: begin
          // past the last segment: last key as it stands
          res_r.out_x        <= $signed(ram_rdata.x);
          res_r.out_y        <= $signed(ram_rdata.y);
          res_r.out_z        <= $signed(ram_rdata.z);
          res_r.segment_used <= 6'(idx_r);
          state_r            <= ST_EMIT;
        end
        ST_SEG_RD: begin
          ka_r   <= ram_rdata;
          dt_r   <= dt_s;
          rem_r  <= {num_s[32], num_s};
          q_r    <= '0;
          dcnt_r <= '0;
          if (dt_s <= 0 || num_s <= 0) begin
            f_r     <= '0;
            state_r <= ST_SQ;
          end else if (num_s >= dt_s) begin
            f_r     <= 17'd65536;
            state_r <= ST_SQ;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r  <= ge ? rem_sh - {1'b0, dt_r} : rem_sh;
          q_r    <= {q_r[14:0], ge};
          dcnt_r <= dcnt_r + 4'd1;
          if (dcnt_r == 4'd15) begin
            f_r     <= {1'b0, q_r[14:0], ge};
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          sq_r    <= f_r * f_r;
          state_r <= ST_SHAPE;
        end
        ST_SHAPE: begin
          case (ka_r.mode)
            MODE_SMOOTH: w_r <= ss_p[48:32];
            MODE_STEP:   w_r <= '0;
            default:     w_r <= f_r;
          endcase
          comp_r  <= '0;
          state_r <= ST_BLEND;
        end
        ST_BLEND: begin
          case (comp_r)
            2'd0:    res_r.out_x <= blend_c;
            2'd1:    res_r.out_y <= blend_c;
            default: res_r.out_z <= blend_c;
          endcase
          res_r.segment_used <= 6'(idx_r);
          comp_r <= comp_r + 2'd1;
          if (comp_r == 2'd2) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // hand over once the output register is free
          if (emit) begin
            out_r   <= res_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // a load transfer never leaves the idle state
  a_load_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_item.opcode == OP_LOAD |=> state_r == ST_IDLE)
    else $error("load transfer started sample work");

  // a new result only ever comes from the emit state
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit");

  // the scan never runs past the store
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> ra_r <= CNT_W'(MAX_KEYS) + CNT_W'(1))
    else $error("scan address out of range");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < {1'b0, dt_r})
    else $error("divider remainder overflow");

endmodule

[rtl/kts_ram.sv]
// ----------------------------------------------------------------------------
// kts_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module kts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
